// ===== src/lrk_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lrk_pkg
// Shared widths, constants and types for the linear ODE step pipeline.
// ---------------------------------------------------------------------------
package lrk_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 17;
    localparam int TIME_W    = 31;
    localparam int DATA_W    = 32;
    localparam int NCOMP     = 4;
    localparam int RK_STAGES = 4;

    localparam int IN_BITS   = TIME_W + NCOMP * DATA_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = NCOMP * DATA_W;

    // working width of states, derivatives and slopes
    localparam int CALC_W = 48;
    localparam int SPLIT  = 24;
    localparam int LO_W   = SPLIT + DT_W;
    localparam int HI_W   = CALC_W - SPLIT + DT_W + 1;
    localparam int PROD_W = HI_W + SPLIT;
    localparam int HALF   = 1 << (FRAC_BITS - 1);

    // forcing term: (th + 10) / 20 as ((th + 10) / 4) / 5
    localparam int TH_W         = TIME_W + 2;
    localparam int M5_W         = TH_W - 2;
    localparam int FORCE_ROUND  = 10;
    localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
    localparam int RECIP5_SHIFT = 34;
    localparam int P5_W         = M5_W + 32;
    localparam int FORCE_W      = P5_W - RECIP5_SHIFT;

    // divide by six as a halving and two base 2^22 digits divided by three
    localparam int SIXTH_ROUND  = 3;
    localparam int DIG_W        = 22;
    localparam int QW           = 2 * DIG_W;
    localparam int RECIP3_W     = 24;
    localparam logic [RECIP3_W-1:0] RECIP3 = 24'hAA_AAAB;
    localparam int RECIP3_SHIFT = 25;
    localparam int PH_W         = DIG_W + RECIP3_W;
    localparam int QH_W         = PH_W - RECIP3_SHIFT;
    localparam int PL_W         = DIG_W + 2 + RECIP3_W;

    // configuration
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD    = 1'b1;
    localparam logic [DT_W-1:0] STEP_SIZE_RESET = 17'd655;
    localparam logic METHOD_EULER = 1'b0;
    localparam logic METHOD_RK4   = 1'b1;

    typedef logic [NCOMP-1:0][DATA_W-1:0] xvec_t;
    typedef logic [NCOMP-1:0][CALC_W-1:0] vec_t;

    typedef enum logic [1:0] {
        RK_K0,
        RK_K1,
        RK_K2,
        RK_K3
    } lrk_kind_t;

    typedef struct packed {
        xvec_t              x;
        vec_t               s;
        vec_t               acc;
        vec_t               k0;
        logic [FORCE_W-1:0] f_now;
        logic [FORCE_W-1:0] f_mid;
        logic [FORCE_W-1:0] f_end;
    } lrk_ctx_t;

    function automatic logic [CALC_W-1:0] sext_x(input logic [DATA_W-1:0] v);
        return {{(CALC_W - DATA_W){v[DATA_W-1]}}, v};
    endfunction

endpackage
`default_nettype wire

// ===== src/lrk_slope.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lrk_slope
// One slope evaluation k = dt * f(t, s), five register stages, with the
// state update that feeds the next evaluation.
// ---------------------------------------------------------------------------
module lrk_slope
    import lrk_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire lrk_kind_t       kind,
    input  wire [DT_W-1:0]       step_size,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire lrk_ctx_t        in_ctx,
    output logic                 out_valid,
    input  wire                  out_ready,
    output lrk_ctx_t             out_ctx
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic ce1, ce2, ce3, ce4, ce5;

    lrk_ctx_t s1_ctx_reg, s2_ctx_reg, s3_ctx_reg, s4_ctx_reg, s5_ctx_reg;
    lrk_ctx_t s5_ctx_next;

    logic [FORCE_W-1:0] force_sel;
    logic [CALC_W-1:0]  fz;
    vec_t               f_next, f_reg;
    logic [LO_W-1:0]          p_lo_next [NCOMP];
    logic [LO_W-1:0]          p_lo_reg  [NCOMP];
    logic signed [HI_W-1:0]   p_hi_next [NCOMP];
    logic signed [HI_W-1:0]   p_hi_reg  [NCOMP];
    logic [PROD_W-1:0]        prod_next [NCOMP];
    logic [PROD_W-1:0]        prod_reg  [NCOMP];
    logic [PROD_W-1:0]        rnd       [NCOMP];
    vec_t                     k_next, k_reg;
    logic [CALC_W-1:0]        hk        [NCOMP];
    logic [CALC_W-1:0]        half_k    [NCOMP];
    logic [CALC_W-1:0]        xe        [NCOMP];

    assign ce5      = !s5_valid_reg || out_ready;
    assign ce4      = !s4_valid_reg || ce5;
    assign ce3      = !s3_valid_reg || ce4;
    assign ce2      = !s2_valid_reg || ce3;
    assign ce1      = !s1_valid_reg || ce2;
    assign in_ready = ce1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            if (ce1) s1_valid_reg <= in_valid;
            if (ce2) s2_valid_reg <= s1_valid_reg;
            if (ce3) s3_valid_reg <= s2_valid_reg;
            if (ce4) s4_valid_reg <= s3_valid_reg;
            if (ce5) s5_valid_reg <= s4_valid_reg;
        end
    end

    // stage 1: derivative of the linear system
    always_comb begin
        case (kind)
            RK_K0:   force_sel = in_ctx.f_now;
            RK_K1:   force_sel = in_ctx.f_mid;
            RK_K2:   force_sel = in_ctx.f_mid;
            RK_K3:   force_sel = in_ctx.f_end;
            default: force_sel = in_ctx.f_end;
        endcase
    end

    assign fz = {{(CALC_W - FORCE_W){1'b0}}, force_sel};

    always_comb begin
        f_next[0] = in_ctx.s[1] - in_ctx.s[0] - in_ctx.s[2] + in_ctx.s[3];
        f_next[1] = in_ctx.s[2] - in_ctx.s[0] - in_ctx.s[3];
        f_next[2] = in_ctx.s[0] - in_ctx.s[1] + in_ctx.s[3] + fz;
        f_next[3] = in_ctx.s[0] - in_ctx.s[3] - fz;
    end

    // stage 2: partial products of dt * f
    // stage 3: partial product sum
    // stage 4: round half away from zero and drop the fraction
    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            p_lo_next[i] = LO_W'(f_reg[i][SPLIT-1:0]) * LO_W'(step_size);
            p_hi_next[i] = HI_W'($signed(f_reg[i][CALC_W-1:SPLIT]))
                         * HI_W'($signed({1'b0, step_size}));
            prod_next[i] = (PROD_W'(p_hi_reg[i]) << SPLIT) + PROD_W'(p_lo_reg[i]);
            rnd[i]       = prod_reg[i] + PROD_W'(HALF)
                         - PROD_W'(prod_reg[i][PROD_W-1]);
            k_next[i]    = rnd[i][FRAC_BITS+CALC_W-1:FRAC_BITS];
        end
    end

    // stage 5: accumulate and form the next evaluation point
    always_comb begin
        s5_ctx_next = s4_ctx_reg;
        for (int i = 0; i < NCOMP; i++) begin
            hk[i]     = k_reg[i] + {{(CALC_W - 1){1'b0}}, ~k_reg[i][CALC_W-1]};
            half_k[i] = {hk[i][CALC_W-1], hk[i][CALC_W-1:1]};
            xe[i]     = sext_x(s4_ctx_reg.x[i]);
            case (kind)
                RK_K0: begin
                    s5_ctx_next.k0[i]  = k_reg[i];
                    s5_ctx_next.acc[i] = k_reg[i];
                    s5_ctx_next.s[i]   = xe[i] + half_k[i];
                end
                RK_K1: begin
                    s5_ctx_next.acc[i] = s4_ctx_reg.acc[i] + {k_reg[i][CALC_W-2:0], 1'b0};
                    s5_ctx_next.s[i]   = xe[i] + half_k[i];
                end
                RK_K2: begin
                    s5_ctx_next.acc[i] = s4_ctx_reg.acc[i] + {k_reg[i][CALC_W-2:0], 1'b0};
                    s5_ctx_next.s[i]   = xe[i] + k_reg[i];
                end
                default: begin
                    s5_ctx_next.acc[i] = s4_ctx_reg.acc[i] + k_reg[i];
                    s5_ctx_next.s[i]   = xe[i] + k_reg[i];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ce1) begin
            s1_ctx_reg <= in_ctx;
            f_reg      <= f_next;
        end
        if (ce2) begin
            s2_ctx_reg <= s1_ctx_reg;
            p_lo_reg   <= p_lo_next;
            p_hi_reg   <= p_hi_next;
        end
        if (ce3) begin
            s3_ctx_reg <= s2_ctx_reg;
            prod_reg   <= prod_next;
        end
        if (ce4) begin
            s4_ctx_reg <= s3_ctx_reg;
            k_reg      <= k_next;
        end
        if (ce5) begin
            s5_ctx_reg <= s5_ctx_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_ctx   = s5_ctx_reg;

endmodule
`default_nettype wire

// ===== src/linear_ode_rk4_euler_step_top.sv =====
`default_nettype none
// Pipeline: 28 register stages from s_ to m_, for Euler and Runge-Kutta alike.
// Throughput: one word per cycle while m_tready is high; every stage has its
// own valid bit and stalls only when the stage after it is full.
// Reset: aresetn (synchronous) empties the pipeline, step_size returns to 655
// and method to fourth-order Runge-Kutta.
// ---------------------------------------------------------------------------
// linear_ode_rk4_euler_step_top
// One Euler or RK4 step of a four-state linear system in signed Q16.16,
// with saturated results.
// ---------------------------------------------------------------------------
module linear_ode_rk4_euler_step_top
    import lrk_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [DT_W-1:0]         cfg_wdata,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire [IN_DATA_W-1:0]    s_tdata,   // time_now, in_a, in_b, in_c, in_d, pad
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata    // out_a, out_b, out_c, out_d
);

    logic [DT_W-1:0] step_size_reg;
    logic            method_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= STEP_SIZE_RESET;
            method_reg    <= METHOD_RK4;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STEP_SIZE: step_size_reg <= cfg_wdata;
                CFG_METHOD:    method_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- forcing terms at t, t + dt/2, t + dt ----------------
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic ce_a, ce_b, ce_c;

    logic [TIME_W:0]     t2;
    logic [TH_W-1:0]     th [3];
    logic [M5_W-1:0]     a_m_next [3];
    logic [M5_W-1:0]     a_m_reg  [3];
    xvec_t               a_x_next, a_x_reg, b_x_reg;
    logic [P5_W-1:0]     b_p_next [3];
    logic [P5_W-1:0]     b_p_reg  [3];
    lrk_ctx_t            c_ctx_next, c_ctx_reg;

    logic     u_valid [RK_STAGES+1];
    logic     u_ready [RK_STAGES+1];
    lrk_ctx_t u_ctx   [RK_STAGES+1];

    assign ce_c     = !c_valid_reg || u_ready[0];
    assign ce_b     = !b_valid_reg || ce_c;
    assign ce_a     = !a_valid_reg || ce_b;
    assign s_tready = ce_a;

    assign t2 = {s_tdata[TIME_W-1:0], 1'b0};

    always_comb begin
        th[0] = TH_W'(t2) + TH_W'(FORCE_ROUND);
        th[1] = TH_W'(t2) + TH_W'(step_size_reg) + TH_W'(FORCE_ROUND);
        th[2] = TH_W'(t2) + TH_W'({step_size_reg, 1'b0}) + TH_W'(FORCE_ROUND);
        for (int i = 0; i < 3; i++) begin
            a_m_next[i] = th[i][TH_W-1:2];
            b_p_next[i] = P5_W'(a_m_reg[i]) * P5_W'(RECIP5);
        end
        for (int i = 0; i < NCOMP; i++) begin
            a_x_next[i] = s_tdata[TIME_W + i*DATA_W +: DATA_W];
        end
    end

    always_comb begin
        c_ctx_next.x     = b_x_reg;
        c_ctx_next.acc   = '0;
        c_ctx_next.k0    = '0;
        c_ctx_next.f_now = b_p_reg[0][P5_W-1:RECIP5_SHIFT];
        c_ctx_next.f_mid = b_p_reg[1][P5_W-1:RECIP5_SHIFT];
        c_ctx_next.f_end = b_p_reg[2][P5_W-1:RECIP5_SHIFT];
        for (int i = 0; i < NCOMP; i++) begin
            c_ctx_next.s[i] = sext_x(b_x_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (ce_a) a_valid_reg <= s_tvalid;
            if (ce_b) b_valid_reg <= a_valid_reg;
            if (ce_c) c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce_a) begin
            a_m_reg <= a_m_next;
            a_x_reg <= a_x_next;
        end
        if (ce_b) begin
            b_p_reg <= b_p_next;
            b_x_reg <= a_x_reg;
        end
        if (ce_c) begin
            c_ctx_reg <= c_ctx_next;
        end
    end

    // ---------------- four slope evaluations ----------------
    assign u_valid[0] = c_valid_reg;
    assign u_ctx[0]   = c_ctx_reg;

    for (genvar j = 0; j < RK_STAGES; j++) begin : g_slope
        lrk_slope u_slope (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .kind      (lrk_kind_t'(j)),
            .step_size (step_size_reg),
            .in_valid  (u_valid[j]),
            .in_ready  (u_ready[j]),
            .in_ctx    (u_ctx[j]),
            .out_valid (u_valid[j+1]),
            .out_ready (u_ready[j+1]),
            .out_ctx   (u_ctx[j+1])
        );
    end

    // ---------------- weighted sum / 6, final add, saturation ----------------
    logic f1_valid_reg, f2_valid_reg, f3_valid_reg, f4_valid_reg, out_valid_reg;
    logic ce_f1, ce_f2, ce_f3, ce_f4, ce_o;

    logic [CALC_W-1:0] m_full [NCOMP];
    logic [QW-1:0]     f1_m2_next [NCOMP];
    logic [QW-1:0]     f1_m2_reg  [NCOMP];
    logic [NCOMP-1:0]  f1_neg_next, f1_neg_reg, f2_neg_reg, f3_neg_reg;
    xvec_t             f1_x_reg, f2_x_reg, f3_x_reg;
    vec_t              f1_k0_reg, f2_k0_reg, f3_k0_reg;

    logic [PH_W-1:0]   f2_ph_next [NCOMP];
    logic [PH_W-1:0]   f2_ph_reg  [NCOMP];
    logic [DIG_W-1:0]  f2_lo_reg  [NCOMP];
    logic [1:0]        f2_hi2_reg [NCOMP];

    logic [QH_W-1:0]   qh_next [NCOMP];
    logic [QH_W-1:0]   f3_qh_reg [NCOMP];
    logic [1:0]        rh [NCOMP];
    logic [PL_W-1:0]   f3_pl_next [NCOMP];
    logic [PL_W-1:0]   f3_pl_reg  [NCOMP];

    logic [QW-2:0]     q [NCOMP];
    logic [CALC_W-1:0] xe [NCOMP];
    vec_t              y_next, f4_y_reg;
    logic [OUT_DATA_W-1:0] out_data_next, out_data_reg;

    assign ce_o       = !out_valid_reg || m_tready;
    assign ce_f4      = !f4_valid_reg || ce_o;
    assign ce_f3      = !f3_valid_reg || ce_f4;
    assign ce_f2      = !f2_valid_reg || ce_f3;
    assign ce_f1      = !f1_valid_reg || ce_f2;
    assign u_ready[RK_STAGES] = ce_f1;

    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            // |acc| + 3, halved
            f1_neg_next[i] = u_ctx[RK_STAGES].acc[i][CALC_W-1];
            m_full[i] = f1_neg_next[i]
                      ? CALC_W'(SIXTH_ROUND) - u_ctx[RK_STAGES].acc[i]
                      : u_ctx[RK_STAGES].acc[i] + CALC_W'(SIXTH_ROUND);
            f1_m2_next[i] = m_full[i][QW:1];

            // high digit / 3
            f2_ph_next[i] = PH_W'(f1_m2_reg[i][QW-1:DIG_W]) * PH_W'(RECIP3);

            // remainder of the high digit joins the low digit
            qh_next[i]    = f2_ph_reg[i][PH_W-1:RECIP3_SHIFT];
            rh[i]         = f2_hi2_reg[i] - qh_next[i][1:0] - {qh_next[i][0], 1'b0};
            f3_pl_next[i] = PL_W'({rh[i], f2_lo_reg[i]}) * PL_W'(RECIP3);

            // apply sign and add to the state; Euler adds k0 to the state instead
            q[i]  = {f3_qh_reg[i], f3_pl_reg[i][RECIP3_SHIFT+DIG_W-1:RECIP3_SHIFT]};
            xe[i] = sext_x(f3_x_reg[i]);
            if (method_reg == METHOD_EULER) begin
                y_next[i] = xe[i] + f3_k0_reg[i];
            end else if (f3_neg_reg[i]) begin
                y_next[i] = xe[i] - CALC_W'(q[i]);
            end else begin
                y_next[i] = xe[i] + CALC_W'(q[i]);
            end

            // clamp to 32 bits
            if (!f4_y_reg[i][CALC_W-1] && (|f4_y_reg[i][CALC_W-2:DATA_W-1])) begin
                out_data_next[i*DATA_W +: DATA_W] = {1'b0, {(DATA_W-1){1'b1}}};
            end else if (f4_y_reg[i][CALC_W-1] && !(&f4_y_reg[i][CALC_W-2:DATA_W-1])) begin
                out_data_next[i*DATA_W +: DATA_W] = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                out_data_next[i*DATA_W +: DATA_W] = f4_y_reg[i][DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            f3_valid_reg  <= 1'b0;
            f4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ce_f1) f1_valid_reg  <= u_valid[RK_STAGES];
            if (ce_f2) f2_valid_reg  <= f1_valid_reg;
            if (ce_f3) f3_valid_reg  <= f2_valid_reg;
            if (ce_f4) f4_valid_reg  <= f3_valid_reg;
            if (ce_o)  out_valid_reg <= f4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce_f1) begin
            f1_m2_reg  <= f1_m2_next;
            f1_neg_reg <= f1_neg_next;
            f1_x_reg   <= u_ctx[RK_STAGES].x;
            f1_k0_reg  <= u_ctx[RK_STAGES].k0;
        end
        if (ce_f2) begin
            f2_ph_reg  <= f2_ph_next;
            for (int i = 0; i < NCOMP; i++) begin
                f2_lo_reg[i]  <= f1_m2_reg[i][DIG_W-1:0];
                f2_hi2_reg[i] <= f1_m2_reg[i][DIG_W+1:DIG_W];
            end
            f2_neg_reg <= f1_neg_reg;
            f2_x_reg   <= f1_x_reg;
            f2_k0_reg  <= f1_k0_reg;
        end
        if (ce_f3) begin
            f3_qh_reg  <= qh_next;
            f3_pl_reg  <= f3_pl_next;
            f3_neg_reg <= f2_neg_reg;
            f3_x_reg   <= f2_x_reg;
            f3_k0_reg  <= f2_k0_reg;
        end
        if (ce_f4) begin
            f4_y_reg <= y_next;
        end
        if (ce_o) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire
